@@ src/lri_pkg.sv @@
// Shared constants and elaboration-time helpers for the logistic regression
// inference block. No dependencies; used by logistic_regression_inference.
package lri_pkg;

  localparam int FEATURE_W   = 16;  // Q4.12 features and weights
  localparam int FRAC_W      = 12;
  localparam int PRODUCT_W   = 2 * FEATURE_W;  // Q8.24 product
  localparam int ACC_W       = 36;  // Q12.24 accumulator, never wraps
  localparam int PROB_W      = 16;  // Q0.16 probability
  localparam int CFG_INDEX_W = 3;

  localparam int FEATURE_COUNT_DEF       = 7;
  localparam int SIGMOID_TABLE_DEPTH_DEF = 256;

  // Register index of the bias; the weights of features 1..N follow it.
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS = 3'd0;

  // Restoring division, used only while the sigmoid table is built.
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], num[k]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid of the centre of bin idx, in Q0.16. exp(-x) is built in Q0.32
  // as a product of exp(-2^b/4096) factors over the set bits of |c|.
  function automatic logic [PROB_W-1:0] sigmoid_entry(input int idx, input int depth);
    logic [63:0] centre;
    logic [63:0] mag;
    logic [63:0] e;
    logic [63:0] f;
    logic [63:0] d;
    logic [63:0] s;
    logic        neg;
    centre = udiv(64'(2 * idx + 1) * 64'd32768, 64'(depth));
    neg    = centre < 64'd32768;
    mag    = neg ? (64'd32768 - centre) : (centre - 64'd32768);
    e      = 64'h1_0000_0000;
    f      = 64'd4293918848;
    for (int b = 0; b < 17; b++) begin
      if (mag[b]) begin
        e = (e * f + 64'h8000_0000) >> 32;
      end
      f = (f * f + 64'h8000_0000) >> 32;
    end
    d = 64'h1_0000_0000 + e;
    s = udiv((64'd1 << 48) + (d >> 1), d);
    if (neg) begin
      return PROB_W'(64'd65536 - s);
    end
    return (s > 64'd65535) ? {PROB_W{1'b1}} : s[PROB_W-1:0];
  endfunction

endpackage

@@ src/logistic_regression_inference.sv @@
// Logistic regression inference: streaming multiply-accumulate, saturation
// and sigmoid table lookup. Depends on lri_pkg.
//
// Usage:
//   Configuration: write the bias (index 0) and the feature weights
//   (index 1..FEATURE_COUNT) over the cfg channel while the block is idle.
//   cfg_ready is always high; other indexes are dropped.
//   Input: one feature per beat on in_valid/in_ready, last_feature set on
//   the final feature of a sample, label sampled with that beat.
//   Output: one beat per sample carrying probability, class_out, correct.
// Throughput: one feature per cycle while the output is not backed up; the
//   accumulator update is a single add per cycle and the product is registered ahead of it.
// Result path: the last feature of a sample passes the input register,
//   product register and sum register, then the result register drives
//   out_valid.
// Reset: clears the valid flags, the accumulator, the bias, the weights and
//   the feature position; a partly received sample is discarded.
// Stall: while out_ready is low the result is held; the pipeline keeps
//   taking features and only backs up once a second finished sample
//   waits behind the held result.
module logistic_regression_inference #(
  parameter int FEATURE_COUNT       = lri_pkg::FEATURE_COUNT_DEF,
  parameter int SIGMOID_TABLE_DEPTH = lri_pkg::SIGMOID_TABLE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lri_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic signed [lri_pkg::FEATURE_W-1:0]  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [lri_pkg::FEATURE_W-1:0]  feature,
  input  logic                                  label,
  input  logic                                  last_feature,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lri_pkg::PROB_W-1:0]            probability,
  output logic                                  class_out,
  output logic                                  correct
);

  localparam int FW       = lri_pkg::FEATURE_W;
  localparam int AW       = lri_pkg::ACC_W;
  localparam int PW       = lri_pkg::PRODUCT_W;
  localparam int FRAC     = lri_pkg::FRAC_W;
  localparam int ZW       = AW - FRAC;
  localparam int IDX_W    = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int IPROD_W  = FW + IDX_W + 1;
  localparam int POS_W    = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT + 1) : 1;

  // Configuration registers.
  logic signed [FW-1:0] bias;
  logic signed [FW-1:0] weights [FEATURE_COUNT];

  // Feature position within the current sample.
  logic [POS_W-1:0] feat_pos;
  logic [POS_W-1:0] feat_pos_next;

  // Input register.
  logic                 s1_valid;
  logic signed [FW-1:0] s1_feature;
  logic signed [FW-1:0] s1_weight;
  logic signed [FW-1:0] s1_bias;
  logic                 s1_first;
  logic                 s1_last;
  logic                 s1_label;

  // Product register.
  logic                 s2_valid;
  logic signed [PW-1:0] s2_product;
  logic signed [FW-1:0] s2_bias;
  logic                 s2_first;
  logic                 s2_last;
  logic                 s2_label;

  // Accumulator and finished-sum register.
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_next;
  logic                 s3_valid;
  logic signed [AW-1:0] s3_sum;
  logic                 s3_label;

  logic out_free;
  logic s3_go;
  logic s3_ready;
  logic s2_go;
  logic s2_ready;
  logic s1_ready;
  logic in_fire;

  logic signed [FW-1:0] weight_sel;
  logic signed [AW-1:0] base;

  logic signed [ZW-1:0]      z_floor;
  logic                      z_hi;
  logic                      z_lo;
  logic [FW-1:0]             zq;
  logic [FW-1:0]             z_offset;
  logic [IPROD_W-1:0]        idx_prod;
  logic [IDX_W-1:0]          sig_idx;
  logic [lri_pkg::PROB_W-1:0] sig_rom [SIGMOID_TABLE_DEPTH];

  // Handshake chain: a non-last item leaves the product stage into the
  // accumulator and never needs room downstream.
  assign out_free  = !out_valid || out_ready;
  assign s3_go     = s3_valid && out_free;
  assign s3_ready  = !s3_valid || out_free;
  assign s2_go     = s2_valid && (!s2_last || s3_ready);
  assign s2_ready  = !s2_valid || s2_go;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_ready  = s1_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (cfg_valid && cfg_index == lri_pkg::REG_BIAS) begin
      bias <= cfg_data;
    end
  end

  for (genvar gw = 0; gw < FEATURE_COUNT; gw++) begin : g_weight
    always_ff @(posedge clk) begin
      if (rst) begin
        weights[gw] <= '0;
      end else if (cfg_valid && cfg_index == lri_pkg::CFG_INDEX_W'(gw + 1)) begin
        weights[gw] <= cfg_data;
      end
    end
  end

  // Weight of the current position; past the last weight it is zero.
  always_comb begin
    weight_sel = '0;
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      if (feat_pos == POS_W'(j)) begin
        weight_sel = weights[j];
      end
    end
  end

  always_comb begin
    if (last_feature) begin
      feat_pos_next = '0;
    end else if (feat_pos < POS_W'(FEATURE_COUNT)) begin
      feat_pos_next = feat_pos + 1'b1;
    end else begin
      feat_pos_next = feat_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feat_pos <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        feat_pos <= feat_pos_next;
      end
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_feature <= feature;
      s1_weight  <= weight_sel;
      s1_bias    <= bias;
      s1_first   <= (feat_pos == '0);
      s1_last    <= last_feature;
      s1_label   <= label;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_product <= s1_feature * s1_weight;
      s2_bias    <= s1_bias;
      s2_first   <= s1_first;
      s2_last    <= s1_last;
      s2_label   <= s1_label;
    end
  end

  // The first feature of a sample starts from the bias in Q12.24.
  assign base     = s2_first ? {{(AW - FW - FRAC){s2_bias[FW-1]}}, s2_bias, {FRAC{1'b0}}}
                             : acc;
  assign acc_next = base + AW'(s2_product);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      s3_valid <= 1'b0;
    end else begin
      if (s2_go) begin
        acc <= acc_next;
      end
      if (s2_go && s2_last) begin
        s3_valid <= 1'b1;
      end else if (s3_go) begin
        s3_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_last) begin
      s3_sum   <= acc_next;
      s3_label <= s2_label;
    end
  end

  // Floor to Q4.12 is the arithmetic drop of the fraction bits; then
  // saturate to the 16-bit range.
  assign z_floor = s3_sum[AW-1:FRAC];
  assign z_hi    = !z_floor[ZW-1] && (|z_floor[ZW-2:FW-1]);
  assign z_lo    = z_floor[ZW-1] && !(&z_floor[ZW-2:FW-1]);

  always_comb begin
    if (z_hi) begin
      zq = {1'b0, {(FW - 1){1'b1}}};
    end else if (z_lo) begin
      zq = {1'b1, {(FW - 1){1'b0}}};
    end else begin
      zq = z_floor[FW-1:0];
    end
  end

  assign z_offset = {~zq[FW-1], zq[FW-2:0]};
  assign idx_prod = IPROD_W'(z_offset) * IPROD_W'(SIGMOID_TABLE_DEPTH);
  assign sig_idx  = idx_prod[FW +: IDX_W];

  for (genvar gi = 0; gi < SIGMOID_TABLE_DEPTH; gi++) begin : g_rom
    assign sig_rom[gi] = lri_pkg::sigmoid_entry(gi, SIGMOID_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      probability <= sig_rom[sig_idx];
      class_out   <= !s3_sum[AW-1];
      correct     <= (!s3_sum[AW-1]) == s3_label;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    feat_pos <= POS_W'(FEATURE_COUNT))
    else $error("feature position beyond the weight count");

  a_pos_clear: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_feature |=> feat_pos == '0)
    else $error("feature position not cleared after the last feature");

  a_sum_kept: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !out_free |=> s3_valid && $stable(s3_sum))
    else $error("finished sum lost while the result register was full");

  a_last_lands: assert property (@(posedge clk) disable iff (rst)
    s2_go && s2_last |=> s3_valid)
    else $error("last feature left the product stage without a sum");

endmodule
